// ----- sv/top_k_value_tracker_assert.svh -----
// Assertion macros for the top-K value tracker.
`ifndef TOP_K_VALUE_TRACKER_ASSERT_SVH
`define TOP_K_VALUE_TRACKER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TKVT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tkvt_pkg.sv -----
// Shared types and constants of the top-K value tracker.
package tkvt_pkg;

  localparam int TKVT_MAX_RANKS = 16;
  localparam int TKVT_TS_W      = 32;
  localparam int TKVT_VAL_W     = 64;
  localparam int TKVT_RANK_W    = 6;
  localparam int TKVT_RK_W      = 7;
  localparam int TKVT_APB_DW    = 32;
  localparam int TKVT_APB_AW    = 2;

  // Register index of ranks_kept.
  localparam logic [TKVT_APB_AW-1:0] TKVT_REG_RANKS_KEPT = 2'd0;

  // Input kinds.
  localparam logic TKVT_KIND_OFFER = 1'b0;
  localparam logic TKVT_KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [TKVT_TS_W-1:0]  ts;
    logic [TKVT_VAL_W-1:0] val;
  } tkvt_rec_t;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the offered record at its sorted position
    logic shift;  // move every entry one place towards the head
  } tkvt_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } tkvt_state_t;

endpackage

// ----- sv/tkvt_cell.sv -----
// One cell of the sorted insertion chain: holds a single ranked record.
module tkvt_cell (
  input  logic              clk,
  input  tkvt_pkg::tkvt_ctl_t ctl,
  input  logic              occupied,
  input  logic              left_gt,
  input  tkvt_pkg::tkvt_rec_t left_rec,
  input  tkvt_pkg::tkvt_rec_t right_rec,
  input  tkvt_pkg::tkvt_rec_t new_rec,
  output tkvt_pkg::tkvt_rec_t rec,
  output logic              gt_real,
  output logic              gt_eff
);
  import tkvt_pkg::*;

  tkvt_rec_t rec_r;
  tkvt_rec_t rec_nxt;

  // An empty cell always yields to the incoming record.
  assign gt_real = $signed(new_rec.val) > $signed(rec_r.val);
  assign gt_eff  = !occupied || gt_real;
  assign rec     = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.shift) begin
      rec_nxt = right_rec;
    end else if (ctl.ins && gt_eff) begin
      rec_nxt = left_gt ? left_rec : new_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// ----- sv/tkvt_chain.sv -----
// Row of insertion cells, sorted largest value first from the head.
module tkvt_chain #(
  parameter int DEPTH = tkvt_pkg::TKVT_MAX_RANKS,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  tkvt_pkg::tkvt_ctl_t ctl,
  input  logic [CNT_W-1:0]  n_eff,
  input  tkvt_pkg::tkvt_rec_t new_rec,
  output tkvt_pkg::tkvt_rec_t head_rec,
  output logic [DEPTH-1:0]  gt_vec
);
  import tkvt_pkg::*;

  tkvt_rec_t        recs [DEPTH];
  logic [DEPTH-1:0] eff_vec;
  logic [DEPTH-1:0] occ_vec;

  assign head_rec = recs[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tkvt_rec_t left_rec;
    tkvt_rec_t right_rec;
    logic      left_gt;

    assign occ_vec[i] = CNT_W'(i) < n_eff;

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_rec = new_rec;
    end else begin : g_body
      assign left_gt  = eff_vec[i-1];
      assign left_rec = recs[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = recs[i];
    end else begin : g_inner
      assign right_rec = recs[i+1];
    end

    tkvt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ_vec[i]),
      .left_gt   (left_gt),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .new_rec   (new_rec),
      .rec       (recs[i]),
      .gt_real   (gt_vec[i]),
      .gt_eff    (eff_vec[i])
    );
  end

endmodule

// ----- sv/top_k_value_tracker.sv -----
// Top-K value tracker: keeps the largest records of a stream and reads them out on a flush.
// Offers: one beat per cycle outside a drain, no result; each cell compares and shifts in
// the same cycle. Flush: N result beats (one when empty), one per cycle while out_stall is
// low, through a single output register; no input is taken until the last is loaded.
// Reset (rst_n low, synchronous) empties the store and sets ranks_kept to 16.
// The record cells hold no reset; only the fill count says which entries are live.
module top_k_value_tracker #(
  parameter int MAX_RANKS = tkvt_pkg::TKVT_MAX_RANKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [tkvt_pkg::TKVT_TS_W-1:0]   in_timestamp,
  input  logic signed [tkvt_pkg::TKVT_VAL_W-1:0] in_value,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tkvt_pkg::TKVT_RANK_W-1:0] out_rank,
  output logic [tkvt_pkg::TKVT_TS_W-1:0]   out_timestamp,
  output logic signed [tkvt_pkg::TKVT_VAL_W-1:0] out_value,
  output logic                             out_entry_valid,
  output logic                             out_last,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkvt_pkg::TKVT_APB_AW-1:0] paddr,
  input  logic [tkvt_pkg::TKVT_APB_DW-1:0] pwdata,
  output logic [tkvt_pkg::TKVT_APB_DW-1:0] prdata,
  output logic                             pready
);
  import tkvt_pkg::*;

  localparam int CNT_W = $clog2(MAX_RANKS + 1);
  localparam int IDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration register. The only register sits at word address zero, so
  // every write that completes lands in it.
  // ---------------------------------------------------------------------------
  logic [TKVT_RK_W-1:0] ranks_kept_r;
  logic [TKVT_RK_W-1:0] ranks_kept_nxt;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {{(TKVT_APB_DW - TKVT_RK_W){1'b0}}, ranks_kept_r};

  always_comb begin
    ranks_kept_nxt = ranks_kept_r;
    if (cfg_wr) begin
      ranks_kept_nxt = pwdata[TKVT_RK_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Effective K: ranks_kept with zero treated as one and anything above the
  // built depth saturated to it.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] k_eff;
  logic [IDX_W-1:0] k_idx;

  always_comb begin
    if (ranks_kept_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (ranks_kept_r > TKVT_RK_W'(MAX_RANKS)) begin
      k_eff = CNT_W'(MAX_RANKS);
    end else begin
      k_eff = CNT_W'(ranks_kept_r);
    end
  end

  assign k_idx = IDX_W'(k_eff - CNT_W'(1));

  // ---------------------------------------------------------------------------
  // Control state.
  // ---------------------------------------------------------------------------
  tkvt_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [TKVT_RANK_W-1:0] rank_r, rank_nxt;

  logic              in_acc;
  logic              offer_acc;
  logic              flush_acc;
  logic [CNT_W-1:0]  fill_clip;
  logic              full;
  logic [CNT_W-1:0]  n_eff;
  logic              drain_load;
  logic              drain_last;
  tkvt_ctl_t         ctl;
  tkvt_rec_t         new_rec;
  tkvt_rec_t         head_rec;
  logic [MAX_RANKS-1:0] gt_vec;

  // Output register state, declared here as the sequencer looks at it.
  logic                   out_valid_r, out_valid_nxt;
  logic [TKVT_RANK_W-1:0] out_rank_r;
  logic [TKVT_TS_W-1:0]   out_ts_r;
  logic [TKVT_VAL_W-1:0]  out_val_r;
  logic                   out_ev_r;
  logic                   out_last_r;

  assign in_acc    = in_valid && !in_stall;
  assign offer_acc = in_acc && (in_kind == TKVT_KIND_OFFER);
  assign flush_acc = in_acc && (in_kind == TKVT_KIND_FLUSH);

  // A lowered ranks_kept trims the smallest entries at the next beat; since
  // cells beyond the fill count are never read, trimming is just the clamp.
  assign fill_clip = (fill_r > k_eff) ? k_eff : fill_r;
  assign full      = (fill_clip == k_eff);

  // When full, the last kept cell is given up to the new record, so the
  // insertion sees one entry fewer.
  assign n_eff   = full ? (k_eff - CNT_W'(1)) : fill_clip;
  assign new_rec = '{ts: in_timestamp, val: in_value};

  // On a drain, the record beats are counted down; a flush of an empty store
  // enters the drain with nothing left and gives a single invalid beat.
  assign drain_last = (rem_r == CNT_W'(0)) || (rem_r == CNT_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (flush_acc) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_load && drain_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall   = 1'b1;
    drain_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_DRAIN: begin
        drain_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Insert only while there is room, or when the offer beats the smallest
  // kept entry. Equal values do not displace, which keeps arrival order.
  assign ctl.ins   = offer_acc && (!full || gt_vec[k_idx]);
  assign ctl.shift = drain_load && (rem_r != CNT_W'(0));

  always_comb begin
    fill_nxt = fill_r;
    rem_nxt  = rem_r;
    rank_nxt = rank_r;
    if (offer_acc) begin
      fill_nxt = full ? fill_clip : (fill_clip + CNT_W'(1));
    end
    if (flush_acc) begin
      // The chain keeps its contents for the drain; the count is cleared now.
      fill_nxt = '0;
      rem_nxt  = fill_clip;
      rank_nxt = '0;
    end
    if (drain_load) begin
      rank_nxt = rank_r + TKVT_RANK_W'(1);
      if (rem_r != CNT_W'(0)) begin
        rem_nxt = rem_r - CNT_W'(1);
      end
    end
  end

  tkvt_chain #(
    .DEPTH (MAX_RANKS),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .n_eff    (n_eff),
    .new_rec  (new_rec),
    .head_rec (head_rec),
    .gt_vec   (gt_vec)
  );

  // ---------------------------------------------------------------------------
  // Output register: holds a result beat while the consumer stalls; the drain waits
  // while a held beat is stalled, and the input side stays stalled until it ends.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (drain_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_load) begin
      out_rank_r <= rank_r;
      out_ev_r   <= (rem_r != CNT_W'(0));
      out_last_r <= drain_last;
      out_ts_r   <= (rem_r != CNT_W'(0)) ? head_rec.ts  : '0;
      out_val_r  <= (rem_r != CNT_W'(0)) ? head_rec.val : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      rem_r        <= '0;
      rank_r       <= '0;
      ranks_kept_r <= TKVT_RK_W'(16);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      rem_r        <= rem_nxt;
      rank_r       <= rank_nxt;
      ranks_kept_r <= ranks_kept_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rank        = out_rank_r;
  assign out_timestamp   = out_ts_r;
  assign out_value       = $signed(out_val_r);
  assign out_entry_valid = out_ev_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "top_k_value_tracker_assert.svh"

  `TKVT_ASSERT_NEXT(a_flush_drain, flush_acc, state_r == ST_DRAIN && fill_r == '0, "bad flush")
  `TKVT_ASSERT_NEXT(a_drain_end, drain_load && drain_last, state_r == ST_IDLE, "drain overran")
  `TKVT_ASSERT_SAME(a_empty, out_valid && !out_entry_valid, out_last && ~|out_rank, "bad empty")
  `TKVT_ASSERT_NEXT(a_grow, offer_acc && !full, fill_r == $past(fill_clip) + CNT_W'(1), "no grow")

endmodule

// ----- test/tb_top_k_value_tracker.sv -----
// Self-checking testbench for the top-K value tracker: random and directed record streams.
module tb_top_k_value_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import tkvt_pkg::*;

  // Run limits, in cycles unless stated otherwise; the hard stop is given as a time.
  localparam int          RANKS_DEPTH      = TKVT_MAX_RANKS;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          DRAIN_LIMIT      = 50000;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          PHASES           = 8;
  localparam int          PHASE_ITEMS      = 49;
  localparam int          PRINT_CAP        = 100;
  localparam realtime     RUN_LIMIT        = 5ms;
  localparam logic [TKVT_APB_AW-1:0] RANKS_KEPT_ADDR = TKVT_APB_AW'(4 * TKVT_REG_RANKS_KEPT);

  localparam logic signed [TKVT_VAL_W-1:0] VAL_MAX = {1'b0, {(TKVT_VAL_W-1){1'b1}}};
  localparam logic signed [TKVT_VAL_W-1:0] VAL_MIN = {1'b1, {(TKVT_VAL_W-1){1'b0}}};
  localparam logic [TKVT_TS_W-1:0]         TS_MAX  = '1;

  // One record or flush beat waiting to be offered to the block.
  typedef struct {
    logic                         kind;
    logic [TKVT_TS_W-1:0]         stamp;
    logic signed [TKVT_VAL_W-1:0] worth;
  } record_beat_t;

  // One ranking line the block is expected to emit.
  typedef struct {
    logic [TKVT_RANK_W-1:0]       rank;
    logic [TKVT_TS_W-1:0]         stamp;
    logic signed [TKVT_VAL_W-1:0] worth;
    logic                         entry_valid;
    logic                         last;
  } ranking_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic                         in_kind      = TKVT_KIND_OFFER;
  logic [TKVT_TS_W-1:0]         in_timestamp = '0;
  logic signed [TKVT_VAL_W-1:0] in_value     = '0;

  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic [TKVT_RANK_W-1:0]       out_rank;
  logic [TKVT_TS_W-1:0]         out_timestamp;
  logic signed [TKVT_VAL_W-1:0] out_value;
  logic                         out_entry_valid;
  logic                         out_last;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [TKVT_APB_AW-1:0]       paddr   = '0;
  logic [TKVT_APB_DW-1:0]       pwdata  = '0;
  logic [TKVT_APB_DW-1:0]       prdata;
  logic                         pready;

  top_k_value_tracker uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_timestamp    (in_timestamp),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rank        (out_rank),
    .out_timestamp   (out_timestamp),
    .out_value       (out_value),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Beats still to be offered, and ranking lines still owed by the block.
  record_beat_t pending_records[$];
  ranking_row_t ranking_due[$];

  // The testbench's own copy of the kept list, held largest value first.
  logic [TKVT_TS_W-1:0]         kept_stamps [RANKS_DEPTH];
  logic signed [TKVT_VAL_W-1:0] kept_worths [RANKS_DEPTH];
  int                           kept_count    = 0;
  logic [TKVT_RK_W-1:0]         ranks_setting = 7'd16;

  int mismatch_count = 0;

  // Idle pattern: mode 0 has a lazy receiver, mode 1 a lazy sender, mode 2 no idling at all.
  int idle_mode = 0;
  int sender_idle_pct   [3] = '{26, 71, 0};
  int receiver_idle_pct [3] = '{71, 26, 0};

  // The stimulus process asks for a long receiver hold-off by bumping this counter; the
  // receiver process notices the change and counts the stretch out itself.
  int long_hold_ask  = 0;
  int long_hold_seen = 0;
  int long_hold_left = 0;

  // Set at every rising edge: the beat on the input channel was accepted at that edge.
  bit in_beat_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or stalls forever.
  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  // Inserts a record behind every kept entry whose value is at least as large, so that
  // equal values keep their order of arrival.  n is the number of entries that survive.
  function automatic void place_in_ranking(int n, logic [TKVT_TS_W-1:0] stamp,
                                           logic signed [TKVT_VAL_W-1:0] worth);
    int pos;
    int i;
    pos = 0;
    while (pos < n && !(worth > kept_worths[pos])) pos++;
    for (i = n; i > pos; i--) begin
      kept_stamps[i] = kept_stamps[i-1];
      kept_worths[i] = kept_worths[i-1];
    end
    kept_stamps[pos] = stamp;
    kept_worths[pos] = worth;
  endfunction

  // Applies one accepted beat to the kept list and queues whatever ranking lines it causes.
  function automatic void advance_ranking(logic kind, logic [TKVT_TS_W-1:0] stamp,
                                          logic signed [TKVT_VAL_W-1:0] worth);
    int           k;
    int           i;
    ranking_row_t row;
    // A setting of zero still keeps one entry; anything beyond the depth saturates.
    k = int'(ranks_setting);
    if (k == 0) k = 1;
    if (k > RANKS_DEPTH) k = RANKS_DEPTH;
    // A lowered setting trims the smallest entries before the beat is looked at.
    if (kept_count > k) kept_count = k;
    if (kind == TKVT_KIND_OFFER) begin
      if (kept_count < k) begin
        place_in_ranking(kept_count, stamp, worth);
        kept_count++;
      end else if (worth > kept_worths[k-1]) begin
        // The smallest entry falls off and the newcomer takes its sorted place.
        place_in_ranking(k - 1, stamp, worth);
      end
    end else if (kept_count == 0) begin
      // An empty store still answers a flush, with a single line marked as no entry.
      row.rank        = '0;
      row.stamp       = '0;
      row.worth       = '0;
      row.entry_valid = 1'b0;
      row.last        = 1'b1;
      ranking_due.insert(ranking_due.size(), row);
    end else begin
      for (i = 0; i < kept_count; i++) begin
        row.rank        = TKVT_RANK_W'(i);
        row.stamp       = kept_stamps[i];
        row.worth       = kept_worths[i];
        row.entry_valid = 1'b1;
        row.last        = (i == kept_count - 1);
        ranking_due.insert(ranking_due.size(), row);
      end
      kept_count = 0;
    end
  endfunction

  // Input driver: a beat stays on the port, unchanged, until the block accepts it.  Only
  // after acceptance, or while idle, does the sender decide afresh whether to offer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (pending_records.size() != 0 && $urandom_range(99) >= sender_idle_pct[idle_mode]) begin
        in_valid     <= 1'b1;
        in_kind      <= pending_records[0].kind;
        in_timestamp <= pending_records[0].stamp;
        in_value     <= pending_records[0].worth;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall driver: a requested long hold-off wins over the random stall pattern.
  always @(negedge clk) begin
    if (long_hold_ask != long_hold_seen) begin
      long_hold_seen <= long_hold_ask;
      long_hold_left <= LONG_HOLD_CYCLES;
      out_stall      <= 1'b1;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct[idle_mode]);
    end
  end

  // Monitor: every accepted input beat feeds the prediction, every accepted result beat is
  // checked field by field against the oldest line still owed.
  always @(posedge clk) begin
    ranking_row_t want;
    in_beat_taken = rst_n && in_valid && !in_stall;
    if (in_beat_taken) begin
      advance_ranking(in_kind, in_timestamp, in_value);
      void'(pending_records.pop_front());
    end
    if (rst_n && out_valid && !out_stall) begin
      if (ranking_due.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected (rank %0d)", out_rank));
      end else begin
        want = ranking_due.pop_front();
        if (out_rank !== want.rank)
          flag_mismatch($sformatf("rank %0d, expected %0d", out_rank, want.rank));
        if (out_timestamp !== want.stamp)
          flag_mismatch($sformatf("rank %0d timestamp %h, expected %h",
                                  want.rank, out_timestamp, want.stamp));
        if (out_value !== want.worth)
          flag_mismatch($sformatf("rank %0d value %0d, expected %0d",
                                  want.rank, out_value, want.worth));
        if (out_entry_valid !== want.entry_valid)
          flag_mismatch($sformatf("rank %0d entry_valid %b, expected %b",
                                  want.rank, out_entry_valid, want.entry_valid));
        if (out_last !== want.last)
          flag_mismatch($sformatf("rank %0d last %b, expected %b",
                                  want.rank, out_last, want.last));
      end
    end
  end

  function automatic void queue_record(logic kind, logic [TKVT_TS_W-1:0] stamp,
                                       logic signed [TKVT_VAL_W-1:0] worth);
    record_beat_t beat;
    beat.kind  = kind;
    beat.stamp = stamp;
    beat.worth = worth;
    pending_records.insert(pending_records.size(), beat);
  endfunction

  // Random beat: values lean towards a narrow band so that ties are common, with the
  // extremes and full-width patterns mixed in.  flush_odds is one flush in that many beats.
  function automatic void queue_random_record(int flush_odds);
    logic                         kind;
    logic [TKVT_TS_W-1:0]         stamp;
    logic signed [TKVT_VAL_W-1:0] worth;
    kind = ($urandom_range(flush_odds - 1) == 0) ? TKVT_KIND_FLUSH : TKVT_KIND_OFFER;
    case ($urandom_range(9))
      8:       stamp = '0;
      9:       stamp = TS_MAX;
      default: stamp = $urandom;
    endcase
    case ($urandom_range(9))
      4, 5, 6: worth = TKVT_VAL_W'($urandom_range(16)) - TKVT_VAL_W'(8);
      7: begin
        case ($urandom_range(3))
          0:       worth = VAL_MAX;
          1:       worth = VAL_MIN;
          2:       worth = '0;
          default: worth = '1;
        endcase
      end
      8, 9:    worth = TKVT_VAL_W'($signed(16'($urandom)));
      default: worth = {$urandom, $urandom};
    endcase
    queue_record(kind, stamp, worth);
  endfunction

  // Waits until every queued beat has gone in and every owed line has come out, then lets
  // the last offers settle inside the block.
  task automatic settle_block();
    int spins;
    spins = 0;
    while ((pending_records.size() != 0 || in_valid || ranking_due.size() != 0)
           && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    if (spins >= DRAIN_LIMIT) flag_mismatch("results still outstanding at the drain limit");
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes ranks_kept through the configuration port and reads it back.  Only the low
  // register bits of the write data count; the rest of the word is deliberately noisy.
  task automatic set_ranks_kept(logic [TKVT_APB_DW-1:0] word);
    logic [TKVT_APB_DW-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RANKS_KEPT_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ranks_setting = word[TKVT_RK_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[TKVT_RK_W-1:0] !== ranks_setting)
      flag_mismatch($sformatf("ranks_kept reads %0d, expected %0d",
                              readback[TKVT_RK_W-1:0], ranks_setting));
  endtask

  initial begin
    int phase_ranks      [PHASES];
    int phase_flush_odds [PHASES];
    int phase;
    int n;

    phase_ranks      = '{127, 1, 5, 16, 64, 3, 17, 8};
    phase_flush_odds = '{30, 4, 8, 40, 12, 6, 8, 10};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset setting of sixteen.  A flush of the empty store comes
    // first, then the value extremes, the timestamp extremes and a pair of equal values
    // that must come back in arrival order.
    queue_record(TKVT_KIND_FLUSH, '0, '0);
    queue_record(TKVT_KIND_OFFER, '0, VAL_MAX);
    queue_record(TKVT_KIND_OFFER, TS_MAX, VAL_MIN);
    queue_record(TKVT_KIND_OFFER, 32'd1, '0);
    queue_record(TKVT_KIND_OFFER, 32'd2, '1);
    queue_record(TKVT_KIND_OFFER, 32'd10, 64'sd5);
    queue_record(TKVT_KIND_OFFER, 32'd11, 64'sd5);
    queue_record(TKVT_KIND_FLUSH, '0, '0);
    settle_block();

    // Keep two: a smaller value is refused, a larger one evicts the smallest, and one equal
    // to the smallest kept value is refused since it is not strictly greater.
    set_ranks_kept(32'hFFFF_FF82);
    queue_record(TKVT_KIND_OFFER, 32'd100, 64'sd20);
    queue_record(TKVT_KIND_OFFER, 32'd101, 64'sd10);
    queue_record(TKVT_KIND_OFFER, 32'd102, 64'sd5);
    queue_record(TKVT_KIND_OFFER, 32'd103, 64'sd20);
    queue_record(TKVT_KIND_OFFER, 32'd104, 64'sd20);
    queue_record(TKVT_KIND_FLUSH, '0, '0);
    settle_block();

    // Fill six entries, then drop the setting to zero: it acts as one, and the flush must
    // return only the largest entry.  A second flush finds the store empty again.
    set_ranks_kept(32'd16);
    for (n = 0; n < 6; n++) queue_record(TKVT_KIND_OFFER, $urandom, {$urandom, $urandom});
    settle_block();
    set_ranks_kept(32'd0);
    queue_record(TKVT_KIND_FLUSH, '0, '0);
    queue_record(TKVT_KIND_FLUSH, '0, '0);
    settle_block();

    // Random phases.  The store is not emptied between phases, so a lowered setting trims
    // whatever the previous phase left behind.  Each phase boundary is also a point where
    // the sender waits for every owed line before going on.
    for (phase = 0; phase < PHASES; phase++) begin
      idle_mode = (phase < 3) ? 0 : (phase < 6) ? 1 : 2;
      set_ranks_kept(($urandom & ~32'h7F) | TKVT_APB_DW'(phase_ranks[phase]));
      for (n = 0; n < PHASE_ITEMS; n++) queue_random_record(phase_flush_odds[phase]);
      if (phase == PHASES - 1) queue_record(TKVT_KIND_FLUSH, '0, '0);
      // With no idling on either side, hold the receiver off for a long stretch while the
      // sender keeps offering, so that a flush backs up and the input gets stalled.
      if (phase == 6) long_hold_ask++;
      settle_block();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
